// File: hw/rtl/sdds_pkg.sv
// Shared types, constants and the double-dabble step for the decimal digit splitter.
// Used by sdds_dabble and saturating_decimal_digit_splitter_core; no dependencies.
package sdds_pkg;

	// Number of decimal digit positions (1 through 9)
	localparam int DIGIT_COUNT = 8;

	// Input word and full BCD width (31 magnitude bits need ten digits)
	localparam int DATA_W     = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;

	// Output mask width and digits carried into each output field
	localparam int MASK_W      = 8;
	localparam int USED_DIGITS = (DIGIT_COUNT < 9) ? DIGIT_COUNT : 9;
	localparam int OUT_DIGITS  = (DIGIT_COUNT < MASK_W) ? DIGIT_COUNT : MASK_W;

	// Conversion steps done by one pipeline stage
	localparam int STEPS_PER_STAGE = 8;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [BCD_W-1:0]  bcd_t;
	typedef logic [3:0]        digit_t;
	typedef logic [MASK_W-1:0] mask_t;

	// Conversion state: BCD accumulator above the binary bits still to shift in
	typedef struct packed {
		bcd_t  bcd;
		word_t bits;
	} dabble_t;

	// 10^USED_DIGITS, evaluated at elaboration
	function automatic word_t digit_limit();
		word_t p;
		p = word_t'(1);
		for (int k = 0; k < USED_DIGITS; k++) begin
			p = word_t'(p * word_t'(10));
		end
		return p;
	endfunction

	localparam word_t DIGIT_LIMIT = digit_limit();

	// One shift-add-3 step: bump digits of five or more, then shift left one bit
	function automatic dabble_t dabble_step(dabble_t x);
		dabble_t r;
		r = x;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (r.bcd[4*d +: 4] >= digit_t'(5)) begin
				r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + digit_t'(3);
			end
		end
		r = r << 1;
		return r;
	endfunction

	// Negative inputs count as zero
	function automatic word_t as_nonneg(word_t raw);
		return raw[DATA_W-1] ? '0 : raw;
	endfunction

endpackage

// File: hw/rtl/sdds_dabble.sv
// One slice of the binary to BCD converter: a fixed run of shift-add-3 steps.
// Depends on sdds_pkg for the step function and the conversion state type.
module sdds_dabble (
	input  sdds_pkg::dabble_t d_in,
	output sdds_pkg::dabble_t d_out
);

	// Chain of steps for this slice
	always_comb begin
		sdds_pkg::dabble_t x;
		x = d_in;
		for (int s = 0; s < sdds_pkg::STEPS_PER_STAGE; s++) begin
			x = sdds_pkg::dabble_step(x);
		end
		d_out = x;
	end

endmodule

// File: hw/rtl/saturating_decimal_digit_splitter_core.sv
// Top level of the saturating decimal digit splitter: clamp, BCD split, show and change masks.
// Depends on sdds_pkg and sdds_dabble (four conversion slices per operand).
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  input    | start / busy     | value, previous_value
//  result   | done (strobe)    | bcd_digits, show_mask, changed_mask
//
// An item is taken on any cycle with start high; busy is never raised.
// Each result passes stages s1 to s4 and result stage s5, one strobe per item.
// The stages hold the 32-step shift-add-3 conversion, eight steps per stage,
// plus one stage for clamping and mask logic.
// Reset clears the stage valid bits only; items in flight are dropped and no results are invented.
module saturating_decimal_digit_splitter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [31:0]         value,
	input  logic signed [31:0]         previous_value,
	output logic                       done,
	output logic        [31:0]         bcd_digits,
	output logic        [7:0]          show_mask,
	output logic        [7:0]          changed_mask
);

	// Conversion state entering and leaving each slice
	sdds_pkg::dabble_t val_in, prv_in;
	sdds_pkg::dabble_t val_d1, val_d2, val_d3, val_d4;
	sdds_pkg::dabble_t prv_d1, prv_d2, prv_d3, prv_d4;

	// Pipeline registers
	sdds_pkg::dabble_t val_s1, val_s2, val_s3, val_s4;
	sdds_pkg::dabble_t prv_s1, prv_s2, prv_s3, prv_s4;
	logic              sat_s1, sat_s2, sat_s3, sat_s4;
	logic              vld_s1, vld_s2, vld_s3, vld_s4, done_s5;
	logic [31:0]       bcd_s5;
	sdds_pkg::mask_t   show_s5, chg_s5;

	// Result stage logic
	logic [31:0]       bcd_n;
	sdds_pkg::mask_t   show_n, chg_n;
	sdds_pkg::word_t   val_nn;

	assign busy = 1'b0;

	// Clamp negatives to zero and start conversion with an empty BCD field
	assign val_nn = sdds_pkg::as_nonneg(sdds_pkg::word_t'(value));
	assign val_in = {sdds_pkg::bcd_t'(0), val_nn};
	assign prv_in = {sdds_pkg::bcd_t'(0),
		sdds_pkg::as_nonneg(sdds_pkg::word_t'(previous_value))};

	// Conversion slices, one per operand per stage
	sdds_dabble u_val1 (.d_in(val_in), .d_out(val_d1));
	sdds_dabble u_prv1 (.d_in(prv_in), .d_out(prv_d1));
	sdds_dabble u_val2 (.d_in(val_s1), .d_out(val_d2));
	sdds_dabble u_prv2 (.d_in(prv_s1), .d_out(prv_d2));
	sdds_dabble u_val3 (.d_in(val_s2), .d_out(val_d3));
	sdds_dabble u_prv3 (.d_in(prv_s2), .d_out(prv_d3));
	sdds_dabble u_val4 (.d_in(val_s3), .d_out(val_d4));
	sdds_dabble u_prv4 (.d_in(prv_s3), .d_out(prv_d4));

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			done_s5 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			done_s5 <= vld_s4;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		val_s1  <= val_d1;
		prv_s1  <= prv_d1;
		sat_s1  <= (val_nn >= sdds_pkg::DIGIT_LIMIT);
		val_s2  <= val_d2;
		prv_s2  <= prv_d2;
		sat_s2  <= sat_s1;
		val_s3  <= val_d3;
		prv_s3  <= prv_d3;
		sat_s3  <= sat_s2;
		val_s4  <= val_d4;
		prv_s4  <= prv_d4;
		sat_s4  <= sat_s3;
		bcd_s5  <= bcd_n;
		show_s5 <= show_n;
		chg_s5  <= chg_n;
	end

	// Saturate, blank leading zeros, compare digits
	always_comb begin
		sdds_pkg::digit_t cd [sdds_pkg::USED_DIGITS];
		logic             nz;
		nz     = 1'b0;
		bcd_n  = '0;
		show_n = '0;
		chg_n  = '0;
		for (int k = 0; k < sdds_pkg::USED_DIGITS; k++) begin
			cd[k] = sat_s4 ? sdds_pkg::digit_t'(9) : val_s4.bcd[4*k +: 4];
		end
		for (int k = 0; k < sdds_pkg::OUT_DIGITS; k++) begin
			bcd_n[4*k +: 4] = cd[k];
			chg_n[k]        = (val_s4.bcd[4*k +: 4] != prv_s4.bcd[4*k +: 4]);
		end
		// A position shows when it or any higher digit is nonzero; position 0 always shows
		for (int k = sdds_pkg::USED_DIGITS - 1; k >= 0; k--) begin
			nz = nz || (cd[k] != '0);
			if (k < sdds_pkg::MASK_W) begin
				show_n[k] = nz;
			end
		end
		show_n[0] = 1'b1;
	end

	assign done         = done_s5;
	assign bcd_digits   = bcd_s5;
	assign show_mask    = show_s5;
	assign changed_mask = chg_s5;

	// Every nibble of a result is a decimal digit
	logic bcd_ok;
	always_comb begin
		bcd_ok = 1'b1;
		for (int k = 0; k < 8; k++) begin
			if (bcd_digits[4*k +: 4] > 4'd9) begin
				bcd_ok = 1'b0;
			end
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted item gave no result after five cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without a matching item");

	a_show_contig: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (show_mask[0] && ((show_mask & (show_mask + 8'd1)) == 8'd0)))
		else $error("show mask is not a run of low ones");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> bcd_ok)
		else $error("result holds a nibble above nine");

endmodule

// File: dv/saturating_decimal_digit_splitter_core_tb.sv
// Self-checking testbench for saturating_decimal_digit_splitter_core: random and edge values
// are split into clamped BCD digits, show and change masks, checked against a local predictor.
// Depends on sdds_pkg and the core RTL only.
module saturating_decimal_digit_splitter_core_tb;

	// One expected split of a value into digits and masks
	typedef struct packed {
		logic [31:0]     bcd;
		sdds_pkg::mask_t show;
		sdds_pkg::mask_t changed;
	} split_result_t;

	// 10^n as a wide unsigned number
	function automatic longint unsigned pow10(int n);
		longint unsigned p;
		p = 1;
		for (int k = 0; k < n; k++) begin
			p = p * 10;
		end
		return p;
	endfunction

	// Clamp, split to BCD, blank leading zeros, mark changed digits
	function automatic split_result_t predict_split(sdds_pkg::word_t val,
		sdds_pkg::word_t prev);
		longint unsigned limit;
		longint unsigned v;
		longint unsigned p;
		longint unsigned a;
		int unsigned     sig;
		split_result_t   r;
		limit = pow10((sdds_pkg::DIGIT_COUNT < 9) ? sdds_pkg::DIGIT_COUNT : 9);
		v = val[31] ? 0 : longint'(val);
		p = prev[31] ? 0 : longint'(prev);
		a = (v >= limit) ? limit - 1 : v;
		r = '0;
		sig = 0;
		for (int k = 0; k < sdds_pkg::DIGIT_COUNT && k < 9; k++) begin
			if (k < 8) begin
				r.bcd[4*k +: 4] = 4'(a % 10);
			end
			if (a != 0) begin
				sig = k + 1;
			end
			a = a / 10;
		end
		if (sig == 0) begin
			sig = 1;
		end
		for (int k = 0; k < sig && k < 8; k++) begin
			r.show[k] = 1'b1;
		end
		// change compare uses the unclamped digits, negatives read as zero
		for (int k = 0; k < sdds_pkg::DIGIT_COUNT && k < 8; k++) begin
			r.changed[k] = (v % 10) != (p % 10);
			v = v / 10;
			p = p / 10;
		end
		return r;
	endfunction

	// Holds predicted splits in item order and compares results against them
	class digit_split_tracker;
		split_result_t pending_splits[$];
		int            mismatches;

		function new();
			mismatches = 0;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		function void note_item(sdds_pkg::word_t val, sdds_pkg::word_t prev);
			pending_splits.push_back(predict_split(val, prev));
		endfunction

		task check_result(logic [31:0] bcd, sdds_pkg::mask_t show,
			sdds_pkg::mask_t changed);
			split_result_t want;
			if (pending_splits.size() == 0) begin
				report_mismatch($sformatf("unexpected result bcd=%h show=%b changed=%b",
					bcd, show, changed));
			end else begin
				want = pending_splits.pop_front();
				if (bcd !== want.bcd)
					report_mismatch($sformatf("bcd_digits %h, want %h", bcd, want.bcd));
				if (show !== want.show)
					report_mismatch($sformatf("show_mask %b, want %b", show, want.show));
				if (changed !== want.changed)
					report_mismatch($sformatf("changed_mask %b, want %b",
						changed, want.changed));
			end
		endtask

		task check_drained();
			if (pending_splits.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", pending_splits.size()));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] value;
	logic signed [31:0] previous_value;
	logic               done;
	logic        [31:0] bcd_digits;
	logic        [7:0]  show_mask;
	logic        [7:0]  changed_mask;

	digit_split_tracker tracker;

	saturating_decimal_digit_splitter_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.previous_value (previous_value),
		.done           (done),
		.bcd_digits     (bcd_digits),
		.show_mask      (show_mask),
		.changed_mask   (changed_mask)
	);

	always #5 clk = ~clk;

	// Watch both channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				tracker.note_item(value, previous_value);
			if (done)
				tracker.check_result(bcd_digits, show_mask, changed_mask);
		end
	end

	// Present one item and hold it until taken
	task drive_item(logic signed [31:0] v, logic signed [31:0] p);
		start          <= 1'b1;
		value          <= v;
		previous_value <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Idle with start low and junk on the payload
	task idle_cycles(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) begin
				value          <= $urandom;
				previous_value <= $urandom;
				@(posedge clk);
			end
		end
	endtask

	// Value drawn from a mix of digit counts, negatives and edges
	function automatic logic signed [31:0] make_value();
		int               n;
		longint unsigned  lim;
		logic signed [31:0] r;
		lim = pow10((sdds_pkg::DIGIT_COUNT < 9) ? sdds_pkg::DIGIT_COUNT : 9);
		case ($urandom_range(0, 9))
			0: r = $urandom;
			1: r = {1'b1, 31'($urandom)};
			7: r = 32'(lim) + $signed($urandom_range(0, 4)) - 2;
			8: r = $urandom_range(0, 20);
			9: r = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: begin
				n = $urandom_range(1, 10);
				if (n == 10)
					r = $urandom_range(32'h7fff_ffff, 1000000000);
				else
					r = $urandom_range(32'(pow10(n) - 1), 32'(pow10(n - 1)));
			end
		endcase
		return r;
	endfunction

	// Previous value, often a near copy so only a few digits differ
	function automatic logic signed [31:0] make_previous(logic signed [31:0] v);
		logic signed [31:0] r;
		case ($urandom_range(0, 5))
			0: r = v;
			1, 2: r = v + $signed($urandom_range(1, 9) * 32'(pow10($urandom_range(0, 9))));
			3: r = v - $signed($urandom_range(1, 9) * 32'(pow10($urandom_range(0, 4))));
			4: r = {1'b1, 31'($urandom)};
			default: r = make_value();
		endcase
		return r;
	endfunction

	initial begin
		int               items;
		int               burst;
		int               wait_cycles;
		logic signed [31:0] v;
		logic signed [31:0] lim;
		tracker        = new();
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		value          = '0;
		previous_value = '0;
		lim            = 32'(pow10((sdds_pkg::DIGIT_COUNT < 9) ? sdds_pkg::DIGIT_COUNT : 9));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, negatives, saturation edge, field extremes
		drive_item(0, 0);
		drive_item(0, 1);
		drive_item(-1, 0);
		drive_item(32'h8000_0000, 32'h7fff_ffff);
		drive_item(32'h7fff_ffff, 32'h8000_0000);
		drive_item(32'h7fff_ffff, 32'h7fff_ffff);
		drive_item(lim - 1, lim - 1);
		drive_item(lim, lim - 1);
		drive_item(lim + 1, 0);
		drive_item(1, -5);
		drive_item(9, 10);
		drive_item(10, 9);
		drive_item(12345678, 87654321);
		drive_item(123456789, 123456788);
		drive_item(1000000000, 0);
		drive_item(-12345, 12345);
		drive_item(32'h5555_5555, 32'haaaa_aaaa);
		drive_item(32'h2aaa_aaaa, 32'h5555_5555);
		drive_item(lim / 10, lim / 10 - 1);
		idle_cycles(3);

		// Random bursts with gaps
		items = 0;
		while (items < 1600) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
			repeat (burst) begin
				v = make_value();
				drive_item(v, make_previous(v));
				items++;
			end
			idle_cycles(($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
				: $urandom_range(0, 4));
		end
		idle_cycles(1);

		wait_cycles = 0;
		while (tracker.pending_splits.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		tracker.check_drained();
		if (tracker.mismatches == 0)
			$display("saturating_decimal_digit_splitter_core test passed");
		else
			$display("saturating_decimal_digit_splitter_core test failed");
		$finish;
	end

	// Hang guard
	initial begin
		#2000000;
		$display("saturating_decimal_digit_splitter_core test failed");
		$finish;
	end

endmodule
